/* src/assert_macros.svh */
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define KWM_CHECK(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define KWM_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/kwm_pkg.sv */
package kwm_pkg;

    // Default sizes
    localparam int MAX_RUNS_DEF  = 8;
    localparam int KEY_BYTES_DEF = 8;

    // Field widths
    localparam int RUN_W     = 3;
    localparam int KEY_F_W   = 64;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = ((RUN_W + KEY_F_W + 7) / 8) * 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] RUN_COUNT_RST = 4'd2;
    localparam logic [CFG_W-1:0] KEY_BYTES_RST = 4'd8;
    localparam logic             DESC_RST      = 1'b0;

    // Input operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_EXHAUST = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic apply;       // take the input beat
        logic scan_start;  // clear the scan, read the first head key
        logic scan_step;   // compare one head key
        logic emit_win;    // load the winner into the output register
        logic emit_done;   // load a done result and re-arm
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic no_live;
        logic wait_refill;
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

/* src/k_way_merge_selector.sv */
// Merge selector for an external sort over up to MAX_RUNS sorted runs.
// Input beats (s side): tuser = operation (0 load key, 1 run exhausted),
// tdata = run_index, next_key. A beat for a run that is not awaiting a
// refill is dropped. Results (m side): tdata = winner_run, winner_key,
// tuser = merge_done. A done result carries zero run and key and re-arms
// all runs from run_count.
// Sequence: a beat that leaves some live run still awaiting a refill goes
// from the check state straight back to idle; a beat that completes the set
// starts the scan that reads one head key per cycle from the head-key RAM and
// compares it with the best so far, then the winner is loaded into the output
// register once it is free; a done result is loaded from the check state.
// s_tready is high only between items. A finished result sits in the output
// register; if the receiver stalls, the next beat is still taken, and the
// block waits only when a new result is due and the register is still full.
// Reset (synchronous, active low) restores run_count 2, key_bytes 8,
// ascending order, and arms runs 0 and 1 as live and awaiting a refill.
// The user makes config writes (index 0 run_count, 1 key_bytes, 2 descending)
// between items; the block does not enforce it; run_count applies at next re-arm.
`include "assert_macros.svh"

module k_way_merge_selector #(
    parameter int MAX_RUNS  = kwm_pkg::MAX_RUNS_DEF,
    parameter int KEY_BYTES = kwm_pkg::KEY_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [kwm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kwm_pkg::CFG_W-1:0]     i_cfg_data,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [kwm_pkg::TDATA_W-1:0]   i_s_tdata,   // [2:0] run_index, [66:3] next_key
    input  logic                          i_s_tuser,   // [0] operation
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [kwm_pkg::TDATA_W-1:0]   o_m_tdata,   // [2:0] winner_run, [66:3] winner_key
    output logic                          o_m_tuser    // [0] merge_done
);

    localparam int PAD_W = kwm_pkg::TDATA_W - kwm_pkg::RUN_W - kwm_pkg::KEY_F_W;

    kwm_pkg::t_cmd s_cmd;
    kwm_pkg::t_sts s_sts;

    logic [kwm_pkg::RUN_W-1:0]   s_run_index;
    logic [kwm_pkg::KEY_F_W-1:0] s_next_key;
    logic [kwm_pkg::RUN_W-1:0]   s_winner_run;
    logic [kwm_pkg::KEY_F_W-1:0] s_winner_key;
    logic                        s_emit;
    logic                        s_done_beat;

    // Unpack the input beat
    assign s_run_index = i_s_tdata[kwm_pkg::RUN_W-1:0];
    assign s_next_key  = i_s_tdata[kwm_pkg::RUN_W +: kwm_pkg::KEY_F_W];

    kwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_sts      (s_sts),
        .o_s_tready (o_s_tready),
        .o_cmd      (s_cmd)
    );

    kwm_dp #(
        .MAX_RUNS  (MAX_RUNS),
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_operation  (i_s_tuser),
        .i_run_index  (s_run_index),
        .i_next_key   (s_next_key),
        .i_cmd        (s_cmd),
        .o_sts        (s_sts),
        .i_m_tready   (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_winner_run (s_winner_run),
        .o_winner_key (s_winner_key),
        .o_merge_done (o_m_tuser)
    );

    // Pack the result beat
    assign o_m_tdata = {{PAD_W{1'b0}}, s_winner_key, s_winner_run};

    // Checks
    assign s_emit      = s_cmd.emit_win || s_cmd.emit_done;
    assign s_done_beat = o_m_tvalid && o_m_tuser;

    `KWM_CHECK(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(s_cmd), "more than one command")
    `KWM_CHECK(a_emit_room, i_clk, i_rst_n, s_emit, s_sts.out_free, "result over a held beat")
    `KWM_CHECK_NEXT(a_done_shown, i_clk, i_rst_n, s_cmd.emit_done, s_done_beat, "done not shown")
    `KWM_CHECK(a_done_clean, i_clk, i_rst_n, s_done_beat, o_m_tdata == '0, "done with nonzero data")

endmodule

/* src/kwm_ram.sv */
module kwm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/kwm_ctrl.sv */
module kwm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  kwm_pkg::t_sts i_sts,
    output logic          o_s_tready,
    output kwm_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Sequencing: take a beat, look at the masks, then emit done, go back to idle, or scan and emit
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_sts.no_live) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_done = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (i_sts.wait_refill) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_win = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/kwm_dp.sv */
module kwm_dp #(
    parameter int MAX_RUNS  = kwm_pkg::MAX_RUNS_DEF,
    parameter int KEY_BYTES = kwm_pkg::KEY_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kwm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [kwm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_operation,
    input  logic [kwm_pkg::RUN_W-1:0]     i_run_index,
    input  logic [kwm_pkg::KEY_F_W-1:0]   i_next_key,
    input  kwm_pkg::t_cmd                 i_cmd,
    output kwm_pkg::t_sts                 o_sts,
    input  logic                          i_m_tready,
    output logic                          o_out_valid,
    output logic [kwm_pkg::RUN_W-1:0]     o_winner_run,
    output logic [kwm_pkg::KEY_F_W-1:0]   o_winner_key,
    output logic                          o_merge_done
);

    localparam int IDX_W = $clog2(MAX_RUNS);
    localparam int KEY_W = 8 * KEY_BYTES;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RUNS - 1);

    // strncmp-style order over nb leading bytes: {a > b, a < b}
    function automatic logic [1:0] key_order(
        input logic [KEY_W-1:0] a,
        input logic [KEY_W-1:0] b,
        input logic [3:0]       nb
    );
        logic       stop;
        logic       gt;
        logic       lt;
        logic [7:0] ba;
        logic [7:0] bb;
        stop = 1'b0;
        gt   = 1'b0;
        lt   = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            ba = a[KEY_W-1-8*i -: 8];
            bb = b[KEY_W-1-8*i -: 8];
            if (!stop && (4'(i) < nb)) begin
                if (ba != bb) begin
                    stop = 1'b1;
                    gt   = (ba > bb);
                    lt   = (ba < bb);
                end else if (ba == 8'd0) begin
                    stop = 1'b1;
                end
            end
        end
        return {gt, lt};
    endfunction

    // Registers and next values
    logic [kwm_pkg::CFG_W-1:0]   r_run_count, n_run_count;
    logic [kwm_pkg::CFG_W-1:0]   r_key_bytes, n_key_bytes;
    logic                        r_desc, n_desc;
    logic [MAX_RUNS-1:0]         r_live, n_live;
    logic [MAX_RUNS-1:0]         r_pend, n_pend;
    logic [IDX_W-1:0]            r_scan_idx, n_scan_idx;
    logic                        r_found, n_found;
    logic [IDX_W-1:0]            r_best_idx, n_best_idx;
    logic [KEY_W-1:0]            r_best_key, n_best_key;
    logic                        r_out_vld, n_out_vld;
    logic [kwm_pkg::RUN_W-1:0]   r_out_run, n_out_run;
    logic [kwm_pkg::KEY_F_W-1:0] r_out_key, n_out_key;
    logic                        r_out_done, n_out_done;

    // Combinational helpers
    logic [MAX_RUNS-1:0] c_arm;
    logic [MAX_RUNS-1:0] c_rst_arm;
    logic [31:0]         c_ri32;
    logic [IDX_W-1:0]    c_idx;
    logic                c_hit;
    logic                c_we;
    logic [IDX_W-1:0]    c_rd_addr;
    logic [KEY_W-1:0]    c_rd_data;
    logic [3:0]          c_nbytes;
    logic [1:0]          c_order;
    logic                c_better;
    logic                c_take;
    logic [31:0]         c_best32;

    // Arm masks: low run_count bits, capped at MAX_RUNS by the mask width
    always_comb begin
        for (int i = 0; i < MAX_RUNS; i++) begin
            c_arm[i]     = (32'(i) < 32'(r_run_count));
            c_rst_arm[i] = (32'(i) < 32'(kwm_pkg::RUN_COUNT_RST));
        end
    end

    // Input beat decode
    assign c_ri32 = 32'(i_run_index);
    assign c_idx  = c_ri32[IDX_W-1:0];
    assign c_hit  = (c_ri32 < 32'(MAX_RUNS)) && r_pend[c_idx];
    assign c_we   = i_cmd.apply && c_hit && (i_operation == kwm_pkg::OP_LOAD);

    // Scan read address runs one entry ahead of the compare
    assign c_rd_addr = (i_cmd.scan_start || (r_scan_idx == LAST_IDX)) ? '0
                                                                      : r_scan_idx + IDX_W'(1);

    kwm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_RUNS)
    ) u_heads (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_idx),
        .i_wdata (i_next_key[kwm_pkg::KEY_F_W-1 -: KEY_W]),
        .i_raddr (c_rd_addr),
        .o_rdata (c_rd_data)
    );

    // Compare the current best against the head key just read
    assign c_nbytes = (r_key_bytes > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : r_key_bytes;
    assign c_order  = key_order(r_best_key, c_rd_data, c_nbytes);
    assign c_better = r_desc ? c_order[0] : c_order[1];
    assign c_take   = r_live[r_scan_idx] && (!r_found || c_better);
    assign c_best32 = 32'(r_best_idx);

    // Next-state logic
    always_comb begin
        n_run_count = r_run_count;
        n_key_bytes = r_key_bytes;
        n_desc      = r_desc;
        n_live      = r_live;
        n_pend      = r_pend;
        n_scan_idx  = r_scan_idx;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_key  = r_best_key;
        n_out_vld   = r_out_vld;
        n_out_run   = r_out_run;
        n_out_key   = r_out_key;
        n_out_done  = r_out_done;

        // register writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kwm_pkg::CFG_RUN_COUNT:  n_run_count = i_cfg_data;
                kwm_pkg::CFG_KEY_BYTES:  n_key_bytes = i_cfg_data;
                kwm_pkg::CFG_DESCENDING: n_desc      = i_cfg_data[0];
                default: ;
            endcase
        end

        // refill or exhaust a pending run
        if (i_cmd.apply && c_hit) begin
            n_pend[c_idx] = 1'b0;
            if (i_operation == kwm_pkg::OP_EXHAUST) begin
                n_live[c_idx] = 1'b0;
            end
        end

        // selection scan
        if (i_cmd.scan_start) begin
            n_scan_idx = '0;
            n_found    = 1'b0;
        end
        if (i_cmd.scan_step) begin
            if (c_take) begin
                n_best_idx = r_scan_idx;
                n_best_key = c_rd_data;
                n_found    = 1'b1;
            end
            if (r_scan_idx != LAST_IDX) begin
                n_scan_idx = r_scan_idx + IDX_W'(1);
            end
        end

        // output register
        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end
        if (i_cmd.emit_done) begin
            n_out_vld  = 1'b1;
            n_out_run  = '0;
            n_out_key  = '0;
            n_out_done = 1'b1;
            n_live     = c_arm;
            n_pend     = c_arm;
        end
        if (i_cmd.emit_win) begin
            n_out_vld  = 1'b1;
            n_out_run  = c_best32[kwm_pkg::RUN_W-1:0];
            n_out_key  = 64'(r_best_key) << (kwm_pkg::KEY_F_W - KEY_W);
            n_out_done = 1'b0;
            n_pend[r_best_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count <= kwm_pkg::RUN_COUNT_RST;
            r_key_bytes <= kwm_pkg::KEY_BYTES_RST;
            r_desc      <= kwm_pkg::DESC_RST;
            r_live      <= c_rst_arm;
            r_pend      <= c_rst_arm;
            r_found     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_run_count <= n_run_count;
            r_key_bytes <= n_key_bytes;
            r_desc      <= n_desc;
            r_live      <= n_live;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_out_vld   <= n_out_vld;
        end
        r_scan_idx <= n_scan_idx;
        r_best_idx <= n_best_idx;
        r_best_key <= n_best_key;
        r_out_run  <= n_out_run;
        r_out_key  <= n_out_key;
        r_out_done <= n_out_done;
    end

    // Status to the controller
    assign o_sts.no_live     = ~|r_live;
    assign o_sts.wait_refill = |(r_live & r_pend);
    assign o_sts.scan_last   = (r_scan_idx == LAST_IDX);
    assign o_sts.out_free    = !r_out_vld || i_m_tready;

    assign o_out_valid  = r_out_vld;
    assign o_winner_run = r_out_run;
    assign o_winner_key = r_out_key;
    assign o_merge_done = r_out_done;

endmodule

/* verif/k_way_merge_selector_tb.sv */
module k_way_merge_selector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_W         = kwm_pkg::RUN_W;
    localparam int KEY_F_W       = kwm_pkg::KEY_F_W;
    localparam int CFG_W         = kwm_pkg::CFG_W;
    localparam int CFG_IDX_W     = kwm_pkg::CFG_IDX_W;
    localparam int TDATA_W       = kwm_pkg::TDATA_W;
    localparam int KEY_BYTES_DEF = kwm_pkg::KEY_BYTES_DEF;
    localparam int NUM_RUNS      = kwm_pkg::MAX_RUNS_DEF;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = NUM_RUNS + 12;  // a full scan plus margin
    localparam int RANDOM_BEATS  = 1150;
    localparam int NUM_PHASES    = 10;

    typedef struct packed {
        logic [RUN_W-1:0]   run;
        logic [KEY_F_W-1:0] key;
        logic               done;
    } t_merge_result;

    // Tracks the head keys and run masks, queues the winner or done result per beat
    class merge_scoreboard;
        logic [CFG_W-1:0]    run_count;
        logic [CFG_W-1:0]    key_bytes;
        logic                descending;
        logic [KEY_F_W-1:0]  head_keys [NUM_RUNS];
        logic [NUM_RUNS-1:0] live_runs;
        logic [NUM_RUNS-1:0] refill_runs;
        t_merge_result       awaited [$];
        int                  errors;

        function void reset_state();
            run_count  = kwm_pkg::RUN_COUNT_RST;
            key_bytes  = kwm_pkg::KEY_BYTES_RST;
            descending = kwm_pkg::DESC_RST;
            foreach (head_keys[i]) head_keys[i] = '0;
            awaited.delete();
            errors = 0;
            rearm();
        endfunction

        // run_count above the run limit saturates
        function void rearm();
            live_runs = '0;
            for (int i = 0; i < NUM_RUNS; i++) begin
                if (i < run_count) live_runs[i] = 1'b1;
            end
            refill_runs = live_runs;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                kwm_pkg::CFG_RUN_COUNT:  run_count  = val;
                kwm_pkg::CFG_KEY_BYTES:  key_bytes  = val;
                kwm_pkg::CFG_DESCENDING: descending = val[0];
                default: ;
            endcase
        endfunction

        // Byte-wise unsigned compare, stops at the first difference or a shared NUL
        function int order_keys(logic [KEY_F_W-1:0] a, logic [KEY_F_W-1:0] b);
            int         n;
            logic [7:0] ca;
            logic [7:0] cb;
            n = (key_bytes > KEY_BYTES_DEF) ? KEY_BYTES_DEF : key_bytes;
            for (int i = 0; i < n; i++) begin
                ca = a[63 - 8*i -: 8];
                cb = b[63 - 8*i -: 8];
                if (ca != cb) return (ca < cb) ? -1 : 1;
                if (ca == 8'h00) return 0;
            end
            return 0;
        endfunction

        function void note_beat(logic op, logic [RUN_W-1:0] run, logic [KEY_F_W-1:0] key);
            logic [KEY_F_W-1:0] width_mask;
            int                 best;
            bit                 found;
            int                 d;
            t_merge_result      res;
            width_mask = '0;
            for (int i = 0; i < KEY_BYTES_DEF; i++) width_mask[63 - 8*i -: 8] = 8'hFF;

            // only a run awaiting a refill takes the beat
            if (run < NUM_RUNS && refill_runs[run]) begin
                if (op == kwm_pkg::OP_LOAD) head_keys[run] = key & width_mask;
                else live_runs[run] = 1'b0;
                refill_runs[run] = 1'b0;
            end

            if (live_runs == '0) begin
                res.run  = '0;
                res.key  = '0;
                res.done = 1'b1;
                awaited.push_back(res);
                rearm();
                return;
            end
            if ((refill_runs & live_runs) != '0) return;

            // best live head, ties to the lowest index
            found = 1'b0;
            best  = 0;
            for (int i = 0; i < NUM_RUNS; i++) begin
                if (live_runs[i]) begin
                    if (!found) begin
                        best  = i;
                        found = 1'b1;
                    end else begin
                        d = order_keys(head_keys[best], head_keys[i]);
                        if ((!descending && d > 0) || (descending && d < 0)) best = i;
                    end
                end
            end
            res.run  = RUN_W'(best);
            res.key  = head_keys[best];
            res.done = 1'b0;
            awaited.push_back(res);
            refill_runs[best] = 1'b1;
        endfunction

        function void check_result(logic [RUN_W-1:0] run, logic [KEY_F_W-1:0] key,
                                   logic done);
            t_merge_result want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, actual run %0d key %h done %0b",
                         $time, run, key, done);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (run !== want.run) begin
                $display("%0t: winner_run expected %0d actual %0d", $time, want.run, run);
                errors++;
            end
            if (key !== want.key) begin
                $display("%0t: winner_key expected %h actual %h", $time, want.key, key);
                errors++;
            end
            if (done !== want.done) begin
                $display("%0t: merge_done expected %0b actual %0b", $time, want.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [TDATA_W-1:0]   i_s_tdata  = '0;  // [2:0] run_index, [66:3] next_key
    logic                 i_s_tuser  = 1'b0; // [0] operation
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [TDATA_W-1:0]   o_m_tdata;         // [2:0] winner_run, [66:3] winner_key
    logic                 o_m_tuser;         // [0] merge_done

    merge_scoreboard sb;
    int unsigned     cycles     = 0;
    bit              feed_busy  = 1'b0;
    int              feed_left  = 0;
    bit              drain_busy = 1'b0;
    int              drain_left = 0;

    k_way_merge_selector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Wait before a beat: a random one in busy stretches, none in quiet stretches
    function automatic int draw_wait(ref bit busy, ref int left);
        if (left == 0) begin
            busy = ($urandom_range(0, 2) != 0);
            left = $urandom_range(10, 60);
        end
        left--;
        return busy ? $urandom_range(0, 12) : 0;
    endfunction

    // Keys from a small byte alphabet give ties, NULs and shared prefixes
    function automatic logic [KEY_F_W-1:0] make_key();
        logic [KEY_F_W-1:0] k;
        logic [7:0]         alphabet [8];
        int                 pos;
        alphabet = '{8'h00, 8'h01, 8'h41, 8'h42, 8'h7F, 8'h80, 8'hFE, 8'hFF};
        k = '0;
        case ($urandom_range(0, 3))
            0: k = {$urandom, $urandom};
            1: for (int i = 0; i < 8; i++) k[63 - 8*i -: 8] = alphabet[$urandom_range(0, 7)];
            2: begin
                k   = sb.head_keys[$urandom_range(0, NUM_RUNS - 1)];
                pos = $urandom_range(0, 7);
                k[63 - 8*pos -: 8] = alphabet[$urandom_range(0, 7)];
            end
            default: k[63 -: 16] = {alphabet[$urandom_range(0, 3)], alphabet[$urandom_range(0, 3)]};
        endcase
        return k;
    endfunction

    // tvalid stays up after a beat; the next call either lowers it or replaces the data
    task automatic send_beat(logic op, logic [RUN_W-1:0] run, logic [KEY_F_W-1:0] key);
        int gap;
        gap = draw_wait(feed_busy, feed_left);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= TDATA_W'({key, run});
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_beat(op, run, key);
    endtask

    // Stop feeding until every result is back and the scan has settled
    task automatic drain_all();
        i_s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [CFG_W-1:0] rc, logic [CFG_W-1:0] kb, logic desc);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= kwm_pkg::CFG_RUN_COUNT;
        i_cfg_data <= rc;
        sb.write_reg(kwm_pkg::CFG_RUN_COUNT, rc);
        @(posedge i_clk);
        i_cfg_idx  <= kwm_pkg::CFG_KEY_BYTES;
        i_cfg_data <= kb;
        sb.write_reg(kwm_pkg::CFG_KEY_BYTES, kb);
        @(posedge i_clk);
        i_cfg_idx  <= kwm_pkg::CFG_DESCENDING;
        i_cfg_data <= CFG_W'(desc);
        sb.write_reg(kwm_pkg::CFG_DESCENDING, CFG_W'(desc));
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly refills for runs awaiting one, some noise that may be dropped
    task automatic random_beat(output bit counted);
        logic [RUN_W-1:0]    run;
        logic                op;
        logic [NUM_RUNS-1:0] open_runs;
        open_runs = sb.refill_runs & sb.live_runs;
        if (open_runs == '0 || $urandom_range(0, 9) == 0) begin
            run = RUN_W'($urandom);
            op  = ($urandom_range(0, 3) == 0) ? kwm_pkg::OP_EXHAUST : kwm_pkg::OP_LOAD;
        end else begin
            do run = RUN_W'($urandom_range(0, NUM_RUNS - 1)); while (!open_runs[run]);
            op = ($urandom_range(0, 7) == 0) ? kwm_pkg::OP_EXHAUST : kwm_pkg::OP_LOAD;
        end
        counted = (sb.live_runs == '0) || sb.refill_runs[run];
        send_beat(op, run, make_key());
    endtask

    // result side
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_wait(drain_busy, drain_left);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            sb.check_result(o_m_tdata[RUN_W-1:0], o_m_tdata[RUN_W +: KEY_F_W], o_m_tuser);
        end
    end

    // stimulus
    initial begin
        bit               counted;
        int               n;
        logic [CFG_W-1:0] rc;
        logic [CFG_W-1:0] kb;
        logic             desc;
        sb = new();
        sb.reset_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: two runs, full keys, ascending
        send_beat(kwm_pkg::OP_LOAD, 3'd0, 64'h4142_0058_0000_0000);
        send_beat(kwm_pkg::OP_LOAD, 3'd3, 64'h1234_5678_9ABC_DEF0);  // run 3 not live: dropped
        send_beat(kwm_pkg::OP_LOAD, 3'd1, 64'h4142_0059_FFFF_FFFF);  // equal up to the NUL
        send_beat(kwm_pkg::OP_LOAD, 3'd0, '1);
        send_beat(kwm_pkg::OP_LOAD, 3'd1, '0);
        send_beat(kwm_pkg::OP_EXHAUST, 3'd0, '0);                     // run 0 has a key: dropped
        send_beat(kwm_pkg::OP_LOAD, 3'd1, '1);                        // tie on all ones: run 0
        send_beat(kwm_pkg::OP_EXHAUST, 3'd0, '0);
        send_beat(kwm_pkg::OP_EXHAUST, 3'd1, '0);                     // merge done
        drain_all();

        // zero key bytes: every key ties; zero run count arms nothing at the next done
        write_regs(4'd0, 4'd0, 1'b0);
        send_beat(kwm_pkg::OP_LOAD, 3'd0, 64'hFF00_0000_0000_0000);
        send_beat(kwm_pkg::OP_LOAD, 3'd1, 64'h0000_0000_0000_0001);
        send_beat(kwm_pkg::OP_EXHAUST, 3'd0, '0);
        send_beat(kwm_pkg::OP_EXHAUST, 3'd1, '0);
        drain_all();

        // oversized run count and key bytes, descending
        write_regs(4'd9, 4'd9, 1'b1);
        send_beat(kwm_pkg::OP_LOAD, 3'd5, 64'hDEAD_BEEF_0000_0000);   // no live run: done
        for (int r = 0; r < NUM_RUNS; r++) send_beat(kwm_pkg::OP_LOAD, RUN_W'(r), make_key());
        drain_all();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       begin rc = 4'd1;  kb = 4'd1;  desc = 1'b0; end
                1:       begin rc = 4'd8;  kb = 4'd8;  desc = 1'b1; end
                2:       begin rc = 4'd15; kb = 4'd15; desc = 1'b0; end
                3:       begin rc = 4'd0;  kb = 4'd0;  desc = 1'b1; end
                default: begin
                    rc   = CFG_W'($urandom_range(1, 8));
                    kb   = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom) :
                                                         CFG_W'($urandom_range(1, 8));
                    desc = 1'($urandom);
                end
            endcase
            write_regs(rc, kb, desc);
            n = 0;
            while (n < RANDOM_BEATS / NUM_PHASES) begin
                random_beat(counted);
                if (counted) n++;
                if ($urandom_range(0, 199) == 0) drain_all();
            end
            drain_all();
        end

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/kwm_pkg.sv
src/kwm_ram.sv
src/kwm_ctrl.sv
src/kwm_dp.sv
src/k_way_merge_selector.sv
verif/k_way_merge_selector_tb.sv
